// File: rtl/tft_pkg.sv
// Shared types and codes for the TCP flow tracker.
// No dependencies; the cell, row and top-level files import this package.
package tft_pkg;

  // Result action codes
  localparam logic [2:0] ACT_NOT_TCP  = 3'd0;
  localparam logic [2:0] ACT_NEW      = 3'd1;
  localparam logic [2:0] ACT_APPEND   = 3'd2;
  localparam logic [2:0] ACT_NO_FLOW  = 3'd3;
  localparam logic [2:0] ACT_HALT_NOW = 3'd4;
  localparam logic [2:0] ACT_FULL     = 3'd5;
  localparam logic [2:0] ACT_HALTED   = 3'd6;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [15:0] FRAG_DF    = 16'h4000;
  localparam logic [7:0]  FLAG_SYN   = 8'h02;
  localparam logic [7:0]  FLAG_SYNACK = 8'h12;

  // Flow numbers travel the row at the widest supported width
  localparam int TOK_FLOW_W = 16;
  localparam int KEY_W      = 96;

  typedef enum logic [1:0] {
    OP_SYN,
    OP_LOOK,
    OP_DROP
  } op_t;

  // Query token handed from cell to cell
  typedef struct packed {
    logic                  vld;
    op_t                   op;
    logic [KEY_W-1:0]      kf;
    logic [KEY_W-1:0]      kr;
    logic                  ins_ok;
    logic [TOK_FLOW_W-1:0] new_flow;
    logic                  fwd_hit;
    logic [TOK_FLOW_W-1:0] fwd_flow;
    logic                  rev_hit;
    logic [TOK_FLOW_W-1:0] rev_flow;
    logic                  placed;
  } tok_t;

endpackage

// File: rtl/tft_if.sv
// Valid/ready channel interfaces for header items and results.
// Depends on nothing but the port widths given here.
interface tft_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_type;
  logic [3:0]  ip_header_words;
  logic [15:0] ip_total_length;
  logic [7:0]  ip_protocol;
  logic [15:0] fragment_field;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  tcp_flags;
  logic [3:0]  tcp_header_words;
  logic [15:0] captured_bytes;

  modport source (output valid, frame_type, ip_header_words, ip_total_length, ip_protocol,
                  fragment_field, source_ip, dest_ip, source_port, dest_port, tcp_flags,
                  tcp_header_words, captured_bytes, input ready);
  modport sink (input valid, frame_type, ip_header_words, ip_total_length, ip_protocol,
                fragment_field, source_ip, dest_ip, source_port, dest_port, tcp_flags,
                tcp_header_words, captured_bytes, output ready);
endinterface

interface tft_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [11:0]        flow_index;
  logic               reply_dir;
  logic signed [16:0] payload_length;
  logic signed [31:0] flow_total_bytes;

  modport source (output valid, action, flow_index, reply_dir, payload_length,
                  flow_total_bytes, input ready);
  modport sink (input valid, action, flow_index, reply_dir, payload_length,
                flow_total_bytes, output ready);
endinterface

// File: rtl/tft_cell.sv
// One flow table entry: key, valid bit and flow number, plus one token stage.
// Depends on tft_pkg.
module tft_cell import tft_pkg::*; #(
  parameter int FLOW_W = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt;
  tok_t              tok_r, tok_nxt;
  logic              match_f, match_r, keep;

  assign match_f = valid_r && (key_r == tok_i.kf);
  assign match_r = valid_r && (key_r == tok_i.kr);

  // Apply the passing query to this entry
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    flow_nxt  = flow_r;
    tok_nxt   = tok_i;
    keep      = valid_r && !(match_f || match_r);
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OP_SYN: begin
          valid_nxt = keep;
          if (!keep && !tok_i.placed && tok_i.ins_ok) begin
            valid_nxt      = 1'b1;
            key_nxt        = tok_i.kf;
            flow_nxt       = tok_i.new_flow[FLOW_W-1:0];
            tok_nxt.placed = 1'b1;
          end
        end
        OP_LOOK: begin
          if (match_f && !tok_i.fwd_hit) begin
            tok_nxt.fwd_hit  = 1'b1;
            tok_nxt.fwd_flow = TOK_FLOW_W'(flow_r);
          end
          if (match_r && !tok_i.rev_hit) begin
            tok_nxt.rev_hit  = 1'b1;
            tok_nxt.rev_flow = TOK_FLOW_W'(flow_r);
          end
        end
        OP_DROP: valid_nxt = keep;
        default: valid_nxt = valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    key_r <= key_nxt;
    flow_r <= flow_nxt;
    tok_r.op <= tok_nxt.op;
    tok_r.kf <= tok_nxt.kf;
    tok_r.kr <= tok_nxt.kr;
    tok_r.ins_ok <= tok_nxt.ins_ok;
    tok_r.new_flow <= tok_nxt.new_flow;
    tok_r.fwd_hit <= tok_nxt.fwd_hit;
    tok_r.fwd_flow <= tok_nxt.fwd_flow;
    tok_r.rev_hit <= tok_nxt.rev_hit;
    tok_r.rev_flow <= tok_nxt.rev_flow;
    tok_r.placed <= tok_nxt.placed;
  end

  assign tok_o = tok_r;

endmodule

// File: rtl/tft_row.sv
// Row of flow table cells; a query token walks one cell per cycle.
// Depends on tft_pkg and tft_cell.
module tft_row import tft_pkg::*; #(
  parameter int ENTRIES = 256,
  parameter int FLOW_W  = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  tok_t link [ENTRIES+1];

  assign link[0] = tok_i;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tft_cell #(.FLOW_W(FLOW_W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (link[i]),
      .tok_o (link[i+1])
    );
  end

  assign tok_o = link[ENTRIES];

endmodule

// File: rtl/tcp_flow_tracker_unit.sv
// Top level of the TCP flow tracker: header checks, sequencer, flow byte memory.
// Depends on tft_pkg, tft_if and tft_row.
//
//  channel  | dir | handshake         | carries
//  in_ch    | in  | valid/ready       | parsed Ethernet/IPv4/TCP header fields
//  out_ch   | out | valid/ready       | action, flow, direction, payload, flow total
//
// One item at a time. Not-TCP and halt results go from the input transfer through
// S_CHECK to S_EMIT, which loads the output register and then frees the block.
// Table work makes one token pass through the cell row (S_WAIT) before S_EMIT;
// a lookup that hits adds the byte-total read/modify/write (S_READ, S_ADD), and
// a SYN-ACK that misses adds a second pass through the row as a drop pass.
// Reset clears all valid bits at once; no sweep.
// A stalled output holds the finished result in the output register.
module tcp_flow_tracker_unit import tft_pkg::*; #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_FLOWS     = 4096
) (
  input logic      clk,
  input logic      rst_n,
  tft_in_if.sink   in_ch,
  tft_out_if.source out_ch
);

  localparam int FW  = $clog2(MAX_FLOWS);
  localparam int FOW = FW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_WAIT, S_READ, S_ADD, S_EMIT
  } state_t;

  state_t state_r;

  // Captured header
  logic [15:0] ether_r, tot_r, frag_r, sp_r, dp_r, cap_r;
  logic [3:0]  ihl_r, doff_r;
  logic [7:0]  proto_r, flags_r;
  logic [31:0] sip_r, dip_r;

  logic             halted_r;
  logic [FOW-1:0]   fo_r;
  logic             synack_r;
  logic [TOK_FLOW_W-1:0] f_r;
  logic [16:0]      plen_r;
  tok_t             launch_r, tok_out, drop_tok;

  logic [2:0]  res_act_r;
  logic [11:0] res_flow_r;
  logic        res_srv_r;
  logic [16:0] res_plen_r;
  logic [31:0] res_tot_r;

  logic        out_valid_r;
  logic [2:0]  out_act_r;
  logic [11:0] out_flow_r;
  logic        out_srv_r;
  logic [16:0] out_plen_r;
  logic [31:0] out_tot_r;

  logic [31:0] flow_mem [MAX_FLOWS];
  logic [31:0] rd_q;
  logic        mem_we;
  logic [FW-1:0] mem_wa;
  logic [31:0] mem_wd;

  // Length checks on the captured header
  logic [15:0] avail, ihl4, doff4;
  logic [17:0] plen_w;
  logic [31:0] plen_ext;
  logic        bad_len, bad_tcp;

  assign ihl4     = {10'd0, ihl_r, 2'b00};
  assign doff4    = {10'd0, doff_r, 2'b00};
  assign avail    = cap_r - 16'd14;
  assign bad_len  = (avail < 16'd20) || (tot_r > avail) || (ihl4 > tot_r);
  assign bad_tcp  = (doff4 > (avail - ihl4)) || (frag_r != FRAG_DF);
  assign plen_w   = {2'b00, tot_r} - {2'b00, ihl4} - {2'b00, doff4};
  assign plen_ext = {{15{plen_r[16]}}, plen_r};

  tft_row #(.ENTRIES(TABLE_ENTRIES), .FLOW_W(FW)) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .tok_i (launch_r),
    .tok_o (tok_out)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  // Turn a returned lookup token into a drop pass
  always_comb begin
    drop_tok    = tok_out;
    drop_tok.op = OP_DROP;
  end

  // Flow byte memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = f_r[FW-1:0];
    mem_wd = rd_q + plen_ext;
    if (state_r == S_ADD) begin
      mem_we = 1'b1;
    end else if (state_r == S_WAIT && tok_out.vld && tok_out.op == OP_SYN && tok_out.placed) begin
      mem_we = 1'b1;
      mem_wa = fo_r[FW-1:0];
      mem_wd = plen_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) flow_mem[mem_wa] <= mem_wd;
    rd_q <= flow_mem[f_r[FW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      halted_r     <= 1'b0;
      fo_r         <= '0;
      launch_r.vld <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      launch_r.vld <= 1'b0;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ether_r  <= in_ch.frame_type;
            ihl_r    <= in_ch.ip_header_words;
            tot_r    <= in_ch.ip_total_length;
            proto_r  <= in_ch.ip_protocol;
            frag_r   <= in_ch.fragment_field;
            sip_r    <= in_ch.source_ip;
            dip_r    <= in_ch.dest_ip;
            sp_r     <= in_ch.source_port;
            dp_r     <= in_ch.dest_port;
            flags_r  <= in_ch.tcp_flags;
            doff_r   <= in_ch.tcp_header_words;
            cap_r    <= in_ch.captured_bytes;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_act_r  <= ACT_NOT_TCP;
          res_flow_r <= '0;
          res_srv_r  <= 1'b0;
          res_plen_r <= '0;
          res_tot_r  <= '0;
          state_r    <= S_EMIT;
          plen_r     <= plen_w[16:0];
          synack_r   <= (flags_r == FLAG_SYNACK);
          priority if (halted_r) begin
            res_act_r <= ACT_HALTED;
          end else if (cap_r < 16'd14) begin
            res_act_r <= ACT_HALT_NOW;
            halted_r  <= 1'b1;
          end else if (ether_r != ETH_IPV4) begin
            res_act_r <= ACT_NOT_TCP;
          end else if (bad_len) begin
            res_act_r <= ACT_HALT_NOW;
            halted_r  <= 1'b1;
          end else if (proto_r != PROTO_TCP) begin
            res_act_r <= ACT_NOT_TCP;
          end else if (bad_tcp) begin
            res_act_r <= ACT_HALT_NOW;
            halted_r  <= 1'b1;
          end else begin
            launch_r.vld      <= 1'b1;
            launch_r.op       <= (flags_r == FLAG_SYN) ? OP_SYN : OP_LOOK;
            launch_r.kf       <= {sip_r, dip_r, sp_r, dp_r};
            launch_r.kr       <= {dip_r, sip_r, dp_r, sp_r};
            launch_r.ins_ok   <= (fo_r < FOW'(MAX_FLOWS));
            launch_r.new_flow <= TOK_FLOW_W'(fo_r[FW-1:0]);
            launch_r.fwd_hit  <= 1'b0;
            launch_r.fwd_flow <= '0;
            launch_r.rev_hit  <= 1'b0;
            launch_r.rev_flow <= '0;
            launch_r.placed   <= 1'b0;
            state_r           <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (tok_out.vld) begin
            res_plen_r <= plen_r;
            res_flow_r <= '0;
            res_srv_r  <= 1'b0;
            res_tot_r  <= '0;
            res_act_r  <= ACT_NO_FLOW;
            state_r    <= S_EMIT;
            unique case (tok_out.op)
              OP_SYN: begin
                if (tok_out.placed) begin
                  res_act_r  <= ACT_NEW;
                  res_flow_r <= tok_out.new_flow[11:0];
                  res_tot_r  <= plen_ext;
                  fo_r       <= fo_r + FOW'(1);
                end else begin
                  res_act_r <= ACT_FULL;
                end
              end
              OP_LOOK: begin
                if (synack_r) begin
                  if (tok_out.rev_hit) begin
                    f_r       <= tok_out.rev_flow;
                    res_srv_r <= 1'b1;
                    state_r   <= S_READ;
                  end else begin
                    launch_r <= drop_tok;
                    state_r  <= S_WAIT;
                  end
                end else if (tok_out.fwd_hit) begin
                  f_r     <= tok_out.fwd_flow;
                  state_r <= S_READ;
                end else if (tok_out.rev_hit) begin
                  f_r       <= tok_out.rev_flow;
                  res_srv_r <= 1'b1;
                  state_r   <= S_READ;
                end
              end
              default: res_act_r <= ACT_NO_FLOW;
            endcase
          end
        end
        S_READ: state_r <= S_ADD;
        S_ADD: begin
          res_act_r  <= ACT_APPEND;
          res_flow_r <= f_r[11:0];
          res_tot_r  <= mem_wd;
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_act_r   <= res_act_r;
            out_flow_r  <= res_flow_r;
            out_srv_r   <= res_srv_r;
            out_plen_r  <= res_plen_r;
            out_tot_r   <= res_tot_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.action           = out_act_r;
  assign out_ch.flow_index       = out_flow_r;
  assign out_ch.reply_dir        = out_srv_r;
  assign out_ch.payload_length   = out_plen_r;
  assign out_ch.flow_total_bytes = out_tot_r;

endmodule
